FILE: rtl/core/ptb_pkg.sv
// Package with the beat types and constants of the palindromic tree builder.
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

    typedef struct packed {
        logic [4:0] symbol;
        logic       restart;
    } t_in_beat;

    typedef struct packed {
        logic [10:0] suffix_node;
        logic [10:0] suffix_length;
        logic        created;
        logic [10:0] distinct_total;
        logic        full_res;
    } t_out_beat;

    localparam logic [4:0] SENTINEL = 5'd31;

endpackage
`default_nettype wire

FILE: rtl/core/ptb_engine.sv
// Sequencer, tree memories and shared compare unit of the palindromic tree builder.
`timescale 1ns / 1ps
`default_nettype none
module ptb_engine #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire ptb_pkg::t_in_beat i_beat,
    output logic                   o_busy,
    output logic                   o_done,
    output ptb_pkg::t_out_beat     o_beat
);
    localparam int NODES = MAX_LEN + 2;
    localparam int NW    = $clog2(NODES + 1);
    localparam int TW    = $clog2(MAX_LEN + 1);
    localparam int SW    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int LW    = NW + 1;
    localparam int CW    = $clog2(NODES) + SW;
    localparam int CD    = NODES << SW;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CLR   = 12'b000000000010,
        S_START = 12'b000000000100,
        S_RD1   = 12'b000000001000,
        S_TX1   = 12'b000000010000,
        S_CMP1  = 12'b000000100000,
        S_EDGE  = 12'b000001000000,
        S_RD2   = 12'b000010000000,
        S_TX2   = 12'b000100000000,
        S_CMP2  = 12'b001000000000,
        S_FIN   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    logic [4:0]           r_text  [MAX_LEN + 1];
    logic signed [LW-1:0] r_len   [NODES];
    logic [NW-1:0]        r_link  [NODES];
    logic [NW-1:0]        r_child [CD];

    logic [NW-1:0]        r_last, r_count, r_cur, r_f, r_nn;
    logic [TW-1:0]        r_tlen;
    logic [SW-1:0]        r_sym;
    logic [4:0]           r_symraw;
    logic [CW-1:0]        r_clr;
    logic                 r_pend;
    logic                 r_created, r_full;
    logic signed [LW-1:0] r_vlen;
    logic [NW-1:0]        r_vlink;
    logic [4:0]           r_tmir;
    logic [NW-1:0]        r_edge;

    logic signed [LW:0]   w_n;
    logic signed [LW:0]   w_pos;
    logic                 w_posok;
    logic                 w_match;
    logic                 w_valid;
    logic                 w_room;
    logic                 w_create;
    logic [NW-1:0]        w_next;
    logic [NW-1:0]        w_laddr;
    logic [NW-1:0]        w_cnode;
    logic [CW-1:0]        w_cidx;

    // Shared compare unit: mirrored position check against the new symbol.
    assign w_n     = $signed({{(LW+1-TW){1'b0}}, r_tlen});
    assign w_pos   = w_n - $signed({r_vlen[LW-1], r_vlen}) - $signed((LW+1)'(1));
    assign w_posok = (w_pos >= $signed((LW+1)'(1))) && (w_pos <= w_n);
    assign w_match = w_posok && (r_tmir == r_symraw);

    assign w_valid  = (32'(r_symraw) < ALPHABET);
    assign w_room   = (32'(r_tlen) < MAX_LEN);
    assign w_create = (r_edge == '0) && (32'(r_count) < NODES);
    assign w_next   = r_created ? r_nn : ((w_valid && !r_full) ? r_edge : r_last);
    assign w_laddr  = (r_state == S_FIN) ? w_next : ((r_state == S_RD2) ? r_f : r_cur);
    assign w_cnode  = (r_state == S_CMP2) ? r_f : r_cur;
    assign w_cidx   = CW'({w_cnode, r_sym});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_last  <= '0;
            r_count <= NW'(2);
            r_tlen  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_symraw  <= i_beat.symbol;
                        r_sym     <= SW'(i_beat.symbol);
                        r_created <= 1'b0;
                        r_full    <= 1'b0;
                        r_clr     <= '0;
                        r_pend    <= i_beat.restart;
                        if (i_beat.restart) begin
                            r_last  <= '0;
                            r_count <= NW'(2);
                            r_tlen  <= '0;
                        end
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                S_START: begin
                    r_cur <= r_last;
                    if (w_valid && w_room) begin
                        r_tlen <= r_tlen + 1'b1;
                    end else if (w_valid) begin
                        r_full <= 1'b1;
                    end
                end
                S_CMP1: begin
                    if (!w_match) r_cur <= r_vlink;
                end
                S_EDGE: begin
                    r_nn <= r_count;
                    if (w_create) begin
                        r_created <= 1'b1;
                        r_f       <= r_vlink;
                    end
                end
                S_CMP2: begin
                    if (!w_match) r_f <= r_vlink;
                end
                S_FIN: begin
                    r_last <= w_next;
                    if (r_created) r_count <= r_count + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Tree memories and their read registers.
    always_ff @(posedge i_clk) begin
        r_edge <= r_child[w_cidx];
        r_tmir <= r_text[w_posok ? TW'(w_pos) : '0];
        if (r_state == S_RD1 || r_state == S_RD2 || r_state == S_FIN) begin
            r_vlen  <= r_len[w_laddr];
            r_vlink <= r_link[w_laddr];
        end
        if (r_state == S_CLR) begin
            r_child[r_clr] <= '0;
            if (32'(r_clr) <= MAX_LEN) begin
                r_text[TW'(r_clr)] <= (r_clr == '0) ? ptb_pkg::SENTINEL : 5'd0;
            end
            if (r_clr == CW'(0)) begin
                r_len[0]  <= '0;
                r_link[0] <= NW'(1);
            end
            if (r_clr == CW'(1)) begin
                r_len[1]  <= '1;
                r_link[1] <= NW'(1);
            end
        end
        if (r_state == S_START && w_valid && w_room) r_text[r_tlen + 1'b1] <= r_symraw;
        if (r_state == S_EDGE && w_create) r_len[r_count] <= r_vlen + $signed(LW'(2));
        if (r_state == S_FIN && r_created) begin
            r_link[r_nn]                 <= r_edge;
            r_child[CW'({r_cur, r_sym})] <= r_nn;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_go) n_state = i_beat.restart ? S_CLR : S_START;
            S_CLR:   if (r_clr == CW'(CD - 1)) n_state = r_pend ? S_START : S_IDLE;
            S_START: n_state = (w_valid && w_room) ? S_RD1 : S_FIN;
            S_RD1:   n_state = S_TX1;
            S_TX1:   n_state = S_CMP1;
            S_CMP1:  n_state = w_match ? S_EDGE : S_RD1;
            S_EDGE:  n_state = w_create ? S_RD2 : S_FIN;
            S_RD2:   n_state = S_TX2;
            S_TX2:   n_state = S_CMP2;
            S_CMP2:  n_state = w_match ? S_FIN : S_RD2;
            S_FIN:   n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);
    always_comb begin
        o_beat.suffix_node    = 11'(r_last);
        o_beat.suffix_length  = r_vlen[LW-1] ? 11'd0 : 11'(r_vlen);
        o_beat.created        = r_created;
        o_beat.distinct_total = 11'(r_count - NW'(2));
        o_beat.full_res       = r_full;
    end
endmodule
`default_nettype wire

FILE: rtl/core/palindromic_tree_builder_top.sv
// Top level of the palindromic tree builder.
// A symbol beat on i_beat is taken at a rising edge where start is high and busy is low.
// busy then stays high until the result beat has been shown.
// o_valid is high for one cycle with the result beat on o_beat; the receiver cannot stall,
// so each result must be taken in that cycle.
// After a beat is taken, the engine steps through START, then RD, TX and CMP for each node that
// the shared mirror compare checks over the suffix-link walk, then EDGE and, when a node is
// created, RD, TX and CMP again over the second walk for its suffix link, then FIN and OUT.
// A symbol outside the alphabet or past capacity goes from START straight to FIN and OUT.
// The engine returns to idle after each result before the next beat can be taken.
// After reset, and before a restart beat is handled, a clearing pass sweeps all
// NODES*2^ceil(log2 ALPHABET) entries (32832 at the defaults) of the edge memory
// while busy stays high.
// Symbols beyond the alphabet or capacity leave the tree unchanged.
`timescale 1ns / 1ps
`default_nettype none
module palindromic_tree_builder_top #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire ptb_pkg::t_in_beat  i_beat,
    output logic                    busy,
    output logic                    o_valid,
    output ptb_pkg::t_out_beat      o_beat
);
    ptb_engine #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(start && !busy), .i_beat(i_beat),
        .o_busy(busy), .o_done(o_valid), .o_beat(o_beat)
    );
endmodule
`default_nettype wire

FILE: rtl/core/ptb_checker.sv
// Port checker for the palindromic tree builder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ptb_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire ptb_pkg::t_out_beat o_beat
);
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result longer than one cycle");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("beat not taken");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_beat.created && o_beat.full_res)) else $error("bad flags");
endmodule

bind palindromic_tree_builder_top ptb_checker u_ptb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_beat(o_beat)
);
`default_nettype wire
